/* hw/rtl/blr_pkg.sv */
// Shared types, widths and codes for the bitplane line rasterizer.
package blr_pkg;

    // Coordinate widths
    localparam int X_BITS = 10;
    localparam int Y_BITS = 8;
    localparam int MAJ_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
    localparam int ERR_BITS = MAJ_BITS + 1;
    localparam int LEFT_BITS = MAJ_BITS + 1;

    // Fixed field widths
    localparam int ADDR_BITS = 16;
    localparam int STRIDE_BITS = 8;
    localparam int MASK_BITS = 8;
    localparam int COLOR_BITS = 3;
    localparam int PROD_BITS = Y_BITS + STRIDE_BITS;

    // Reset values of the configuration registers and the edge bits of a pixel mask
    localparam logic [ADDR_BITS-1:0] BASE_RESET = 16'hC000;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 8'd80;
    localparam logic [MASK_BITS-1:0] LEFT_BIT = 8'h80;
    localparam logic [MASK_BITS-1:0] RIGHT_BIT = 8'h01;

    // Input tdata layout, lowest bits first
    localparam int XS_LO = 0;
    localparam int YS_LO = XS_LO + X_BITS;
    localparam int XE_LO = YS_LO + Y_BITS;
    localparam int YE_LO = XE_LO + X_BITS;
    localparam int CO_LO = YE_LO + Y_BITS;
    localparam int IN_FIELD_BITS = CO_LO + COLOR_BITS;
    localparam int IN_DATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bits first
    localparam int OUT_FIELD_BITS = ADDR_BITS + MASK_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_STRIDE = 1'b1;

    // Item kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [X_BITS-1:0]     x_start;
        logic [Y_BITS-1:0]     y_start;
        logic [X_BITS-1:0]     x_end;
        logic [Y_BITS-1:0]     y_end;
        logic [COLOR_BITS-1:0] color;
    } blr_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  byte_address;
        logic [MASK_BITS-1:0]  pixel_mask;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last;
    } blr_result_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   base_address;
        logic [STRIDE_BITS-1:0] row_stride;
    } blr_cfg_t;

endpackage

/* hw/rtl/blr_cfg_regs.sv */
// Configuration registers: frame base address and row stride.
module blr_cfg_regs import blr_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [ADDR_BITS-1:0]    cfg_data,
    output blr_cfg_t                cfg
);

    logic [ADDR_BITS-1:0]   base_reg;
    logic [STRIDE_BITS-1:0] stride_reg;

    assign cfg_ready = 1'b1;

    // Latch the addressed register on a write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= BASE_RESET;
            stride_reg <= STRIDE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BASE_ADDRESS: base_reg   <= cfg_data;
                REG_ROW_STRIDE:   stride_reg <= cfg_data[STRIDE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.base_address = base_reg;
    assign cfg.row_stride   = stride_reg;

endmodule

/* hw/rtl/blr_in_stage.sv */
// Input register: holds one accepted item until the step logic takes it.
module blr_in_stage import blr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  blr_item_t in_item,
    output logic      item_valid,
    output blr_item_t item,
    input  logic      item_take
);

    logic      valid_reg;
    blr_item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign in_ready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (item_take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/blr_step.sv */
// Line state and one Bresenham step: sets up on load, emits one pixel per tick while a line is open.
module blr_step import blr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  blr_cfg_t    cfg,
    input  logic        item_valid,
    input  blr_item_t   item,
    output logic        item_take,
    input  logic        out_free,
    output logic        res_valid,
    output blr_result_t res
);

    // Line state
    logic [ADDR_BITS-1:0]       ptr_reg, ptr_next;
    logic [MASK_BITS-1:0]       mask_reg, mask_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic [LEFT_BITS-1:0]       left_reg, left_next;
    logic [X_BITS-1:0]          dx_reg, dx_next;
    logic [Y_BITS-1:0]          dy_reg, dy_next;
    logic                       down_reg, down_next;
    logic                       xmaj_reg, xmaj_next;
    logic [COLOR_BITS-1:0]      color_reg, color_next;
    logic                       busy_reg, busy_next;

    // Load setup
    logic                   swap;
    logic [X_BITS-1:0]      x0, x1;
    logic [Y_BITS-1:0]      y0, y1;
    logic [X_BITS-1:0]      ld_dx;
    logic [Y_BITS-1:0]      ld_dy;
    logic                   ld_down;
    logic                   ld_xmaj;
    logic [MAJ_BITS-1:0]    ld_major;
    logic [PROD_BITS-1:0]   row_off;

    // Tick step
    logic [MAJ_BITS-1:0]        st_minor, st_major;
    logic signed [ERR_BITS-1:0] err_sub;
    logic                       err_neg;
    logic                       col_step, row_step;
    logic [ADDR_BITS-1:0]       col_inc, row_delta;

    logic is_load, tick_fire;

    assign is_load   = (item.op == OP_LOAD);
    assign item_take = item_valid && (is_load || !busy_reg || out_free);
    assign tick_fire = item_take && !is_load && busy_reg;

    // Order endpoints so x rises, then find deltas and the major axis
    always_comb begin
        swap     = item.x_start > item.x_end;
        x0       = swap ? item.x_end   : item.x_start;
        y0       = swap ? item.y_end   : item.y_start;
        x1       = swap ? item.x_start : item.x_end;
        y1       = swap ? item.y_start : item.y_end;
        ld_dx    = x1 - x0;
        ld_down  = (y0 <= y1);
        ld_dy    = ld_down ? (y1 - y0) : (y0 - y1);
        ld_xmaj  = MAJ_BITS'(ld_dx) > MAJ_BITS'(ld_dy);
        ld_major = ld_xmaj ? MAJ_BITS'(ld_dx) : MAJ_BITS'(ld_dy);
        row_off  = PROD_BITS'(y0) * PROD_BITS'(cfg.row_stride);
    end

    // Step the error term; take a minor step when it goes negative
    always_comb begin
        st_minor  = xmaj_reg ? MAJ_BITS'(dy_reg) : MAJ_BITS'(dx_reg);
        st_major  = xmaj_reg ? MAJ_BITS'(dx_reg) : MAJ_BITS'(dy_reg);
        err_sub   = err_reg - $signed(ERR_BITS'(st_minor));
        err_neg   = err_sub[ERR_BITS-1];
        col_step  = xmaj_reg || err_neg;
        row_step  = !xmaj_reg || err_neg;
        col_inc   = ADDR_BITS'(col_step && mask_reg[0]);
        row_delta = !row_step ? '0 :
                    down_reg  ? ADDR_BITS'(cfg.row_stride) :
                                ADDR_BITS'(-ADDR_BITS'(cfg.row_stride));
    end

    // Next line state
    always_comb begin
        ptr_next   = ptr_reg;
        mask_next  = mask_reg;
        err_next   = err_reg;
        left_next  = left_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        down_next  = down_reg;
        xmaj_next  = xmaj_reg;
        color_next = color_reg;
        busy_next  = busy_reg;
        if (item_take && is_load) begin
            ptr_next   = cfg.base_address + ADDR_BITS'(row_off) + ADDR_BITS'(x0 >> 3);
            mask_next  = LEFT_BIT >> x0[2:0];
            err_next   = $signed(ERR_BITS'(ld_major >> 1));
            left_next  = LEFT_BITS'(ld_major) + LEFT_BITS'(1);
            dx_next    = ld_dx;
            dy_next    = ld_dy;
            down_next  = ld_down;
            xmaj_next  = ld_xmaj;
            color_next = item.color;
            busy_next  = 1'b1;
        end else if (tick_fire) begin
            ptr_next  = ptr_reg + col_inc + row_delta;
            if (col_step) begin
                mask_next = (mask_reg == RIGHT_BIT) ? LEFT_BIT : (mask_reg >> 1);
            end
            err_next  = err_neg ? err_sub + $signed(ERR_BITS'(st_major)) : err_sub;
            left_next = left_reg - LEFT_BITS'(1);
            busy_next = (left_reg != LEFT_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            mask_reg  <= '0;
            err_reg   <= '0;
            left_reg  <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            down_reg  <= 1'b0;
            xmaj_reg  <= 1'b0;
            color_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            ptr_reg   <= ptr_next;
            mask_reg  <= mask_next;
            err_reg   <= err_next;
            left_reg  <= left_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            down_reg  <= down_next;
            xmaj_reg  <= xmaj_next;
            color_reg <= color_next;
            busy_reg  <= busy_next;
        end
    end

    // Current pixel goes out before the advance
    assign res_valid         = tick_fire;
    assign res.byte_address  = ptr_reg;
    assign res.pixel_mask    = mask_reg;
    assign res.pixel_color   = color_reg;
    assign res.last          = (left_reg == LEFT_BITS'(1));

endmodule

/* hw/rtl/blr_out_stage.sv */
// Output register: holds one pixel write until the sink takes it.
module blr_out_stage import blr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        res_valid,
    input  blr_result_t res,
    output logic        out_free,
    output logic        out_valid,
    input  logic        out_ready,
    output blr_result_t out_res
);

    logic        valid_reg;
    blr_result_t res_reg;

    assign out_free = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* hw/rtl/bitplane_line_rasterizer.sv */
// Top level of the bitplane line rasterizer.
//
//  channel  direction  handshake              payload
//  s_       in         s_tvalid / s_tready    s_tuser = op, s_tdata = endpoints, color
//  m_       out        m_tvalid / m_tready    m_tdata = address, mask, color; m_tlast
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the m_ side takes pixels: each item passes the input register
// and the Bresenham step logic (the y * stride product on load, one add and compare on
// tick), and a tick that draws lands its pixel in the output register.
// Reset (aresetn low, synchronous) idles the line and restores the register defaults.
// A stalled m_ side holds ticks in the input register; loads and idle ticks still drain.
module bitplane_line_rasterizer import blr_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,  // x_start, y_start, x_end, y_end, color
    input  logic                     s_tuser,  // op
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,  // byte_address, pixel_mask, pixel_color
    output logic                     m_tlast,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ADDR_BITS-1:0]     cfg_data
);

    blr_cfg_t    cfg;
    blr_item_t   in_item, item;
    blr_result_t res, out_res;
    logic        item_valid, item_take, out_free, res_valid;

    // Unpack the input item
    assign in_item.op      = s_tuser;
    assign in_item.x_start = s_tdata[XS_LO +: X_BITS];
    assign in_item.y_start = s_tdata[YS_LO +: Y_BITS];
    assign in_item.x_end   = s_tdata[XE_LO +: X_BITS];
    assign in_item.y_end   = s_tdata[YE_LO +: Y_BITS];
    assign in_item.color   = s_tdata[CO_LO +: COLOR_BITS];

    blr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    blr_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    blr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the pixel write
    assign m_tdata = OUT_DATA_BITS'({out_res.pixel_color, out_res.pixel_mask,
                                     out_res.byte_address});
    assign m_tlast = out_res.last;

endmodule

/* hw/rtl/blr_checker.sv */
// Port-level checks for the bitplane line rasterizer, bound to the top level.
module blr_checker import blr_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata,
    input logic                     m_tlast
);

    // A pixel held by the sink keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel write changed while stalled");

    // Every pixel write selects exactly one bit of its byte
    a_mask_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[ADDR_BITS +: MASK_BITS]))
        else $error("pixel mask is not one-hot");

    // With the output register empty the input side never stalls
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Reset drops any pending pixel
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("pixel write pending after reset");

endmodule

bind bitplane_line_rasterizer blr_checker u_blr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* test/bitplane_line_rasterizer_tb.sv */
// Self-checking testbench for the bitplane line rasterizer: stream stimulus, pixel predictor.
module bitplane_line_rasterizer_tb;
    import blr_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int MAX_REPORTS = 10;
    localparam int X_TOP = 639;
    localparam int Y_TOP = 199;
    localparam int SETTLE_CUT = 16;

    // Predict pixel writes from accepted items and check them in order
    class pixel_scoreboard;
        logic [ADDR_BITS-1:0]   base_addr = BASE_RESET;
        logic [STRIDE_BITS-1:0] stride = STRIDE_RESET;
        logic [ADDR_BITS-1:0]   ptr = '0;
        logic [MASK_BITS-1:0]   mask = '0;
        int                     err_acc = 0;
        int                     pixels_to_go = 0;
        int                     run_x = 0;
        int                     run_y = 0;
        bit                     rows_rise = 0;
        bit                     along_x = 0;
        logic [COLOR_BITS-1:0]  pen = '0;
        bit                     drawing = 0;
        blr_result_t            pending[$];
        int                     errors = 0;

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [ADDR_BITS-1:0] data);
            if (idx == REG_BASE_ADDRESS) begin
                base_addr = data;
            end else begin
                stride = data[STRIDE_BITS-1:0];
            end
        endfunction

        function void step_column();
            mask = mask >> 1;
            if (mask == '0) begin
                mask = LEFT_BIT;
                ptr = ptr + 1'b1;
            end
        endfunction

        function void step_row();
            if (rows_rise) begin
                ptr = ptr + stride;
            end else begin
                ptr = ptr - stride;
            end
        endfunction

        // Return 1 when the item changes the line state
        function bit note_item(blr_item_t it);
            int x0;
            int y0;
            int x1;
            int y1;
            int tmp;
            int major;
            blr_result_t pix;
            if (it.op == OP_LOAD) begin
                x0 = it.x_start;
                y0 = it.y_start;
                x1 = it.x_end;
                y1 = it.y_end;
                // swap so that x rises
                if (x0 > x1) begin
                    tmp = x0; x0 = x1; x1 = tmp;
                    tmp = y0; y0 = y1; y1 = tmp;
                end
                run_x = x1 - x0;
                run_y = (y1 >= y0) ? y1 - y0 : y0 - y1;
                ptr = ADDR_BITS'(int'(base_addr) + y0 * int'(stride) + (x0 >> 3));
                mask = LEFT_BIT >> (x0 % 8);
                rows_rise = (y0 <= y1);
                along_x = (run_x > run_y);
                major = along_x ? run_x : run_y;
                err_acc = major / 2;
                pixels_to_go = major + 1;
                pen = it.color;
                drawing = 1;
                return 1;
            end
            if (!drawing) begin
                return 0;
            end
            pix.byte_address = ptr;
            pix.pixel_mask = mask;
            pix.pixel_color = pen;
            pix.last = (pixels_to_go == 1);
            pending.push_back(pix);
            // advance along the major axis, then the minor one on error underflow
            if (along_x) begin
                step_column();
                err_acc -= run_y;
                if (err_acc < 0) begin
                    err_acc += run_x;
                    step_row();
                end
            end else begin
                step_row();
                err_acc -= run_x;
                if (err_acc < 0) begin
                    err_acc += run_y;
                    step_column();
                end
            end
            pixels_to_go--;
            if (pixels_to_go == 0) begin
                drawing = 0;
            end
            return 1;
        endfunction

        function void check_pixel(blr_result_t got);
            blr_result_t exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected pixel write: addr %h mask %h color %0d last %0b",
                             got.byte_address, got.pixel_mask, got.pixel_color, got.last);
                end
                return;
            end
            exp = pending.pop_front();
            if (got.byte_address !== exp.byte_address || got.pixel_mask !== exp.pixel_mask ||
                got.pixel_color !== exp.pixel_color || got.last !== exp.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display({"pixel mismatch: expected addr %h mask %h color %0d last %0b,",
                              " got addr %h mask %h color %0d last %0b"},
                             exp.byte_address, exp.pixel_mask, exp.pixel_color, exp.last,
                             got.byte_address, got.pixel_mask, got.pixel_color, got.last);
                end
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;   // x_start, y_start, x_end, y_end, color
    logic                     s_tuser = 1'b0; // op
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;        // byte_address, pixel_mask, pixel_color
    logic                     m_tlast;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [ADDR_BITS-1:0]     cfg_data = '0;

    pixel_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  active_items = 0;
    bit  hold_armed = 0;
    int  hold_count = 0;

    bitplane_line_rasterizer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Check accepted pixels, then pick the next ready level
    always @(posedge aclk) begin
        blr_result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.byte_address = m_tdata[ADDR_BITS-1:0];
            seen.pixel_mask = m_tdata[ADDR_BITS+MASK_BITS-1:ADDR_BITS];
            seen.pixel_color = m_tdata[OUT_FIELD_BITS-1:ADDR_BITS+MASK_BITS];
            seen.last = m_tlast;
            sb.check_pixel(seen);
        end
        if (hold_armed && hold_count < HOLD_CYCLES) begin
            hold_count++;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hard stop if the run hangs
    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    function automatic blr_item_t make_item(logic op, int x0, int y0, int x1, int y1, int c);
        blr_item_t it;
        it.op = op;
        it.x_start = X_BITS'(x0);
        it.y_start = Y_BITS'(y0);
        it.x_end = X_BITS'(x1);
        it.y_end = Y_BITS'(y1);
        it.color = COLOR_BITS'(c);
        return it;
    endfunction

    // Offer one item after a random gap and wait for accept
    task automatic push_item(input blr_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= IN_DATA_BITS'({it.color, it.y_end, it.x_end, it.y_start, it.x_start});
        do @(posedge aclk); while (!s_tready);
        if (sb.note_item(it)) begin
            active_items++;
        end
    endtask

    // Tick with random content in the ignored fields
    task automatic push_tick();
        push_item(make_item(OP_TICK, $urandom_range(X_TOP), $urandom_range(Y_TOP),
                            $urandom_range(X_TOP), $urandom_range(Y_TOP), $urandom_range(7)));
    endtask

    // Finish the open line, drain all pixels and let the pipeline empty
    task automatic settle();
        // Replace a long open line by a single point
        if (sb.drawing && sb.pixels_to_go > SETTLE_CUT) begin
            push_item(make_item(OP_LOAD, 0, 0, 0, 0, 0));
        end
        while (sb.drawing) begin
            push_tick();
        end
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [ADDR_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic int clamp(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // A tick, or a load with ticks: mostly short lines, some long, some cut by the next load
    task automatic draw_line();
        int x0;
        int y0;
        int x1;
        int y1;
        int px;
        int ticks;
        if ($urandom_range(9) == 0) begin
            push_tick();
            return;
        end
        x0 = $urandom_range(X_TOP);
        y0 = $urandom_range(Y_TOP);
        if ($urandom_range(4) == 0) begin
            x1 = $urandom_range(X_TOP);
            y1 = $urandom_range(Y_TOP);
        end else begin
            x1 = clamp(x0 + int'($urandom_range(40)) - 20, X_TOP);
            y1 = clamp(y0 + int'($urandom_range(24)) - 12, Y_TOP);
        end
        push_item(make_item(OP_LOAD, x0, y0, x1, y1, $urandom_range(7)));
        px = ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > px) begin
            px = (y1 > y0) ? y1 - y0 : y0 - y1;
        end
        px = px + 1;
        if (px > 48 && $urandom_range(7) != 0) begin
            ticks = $urandom_range(1, 48);
        end else if ($urandom_range(4) == 0) begin
            ticks = $urandom_range(px - 1);
        end else begin
            ticks = px + $urandom_range(2);
        end
        repeat (ticks) push_tick();
    endtask

    task automatic run_lines(input int budget);
        int start;
        start = active_items;
        while (active_items - start < budget) begin
            draw_line();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines, then random ones, on reset defaults
        send_idle_pct = 25;
        recv_idle_pct = 83;
        push_tick();
        push_item(make_item(OP_LOAD, 0, 0, 0, 0, 7));
        push_tick();
        push_tick();
        push_item(make_item(OP_LOAD, X_TOP, Y_TOP, 636, 197, 0));
        push_tick();
        push_item(make_item(OP_LOAD, 5, 3, 7, 10, 2));
        repeat (8) push_tick();
        push_item(make_item(OP_LOAD, 0, Y_TOP, X_TOP, 0, 1));
        push_tick();
        push_tick();
        push_item(make_item(OP_LOAD, 7, 100, 8, 100, 3));
        push_tick();
        push_tick();
        run_lines(220);
        settle();

        // Address wrap with the widest stride
        write_reg(REG_BASE_ADDRESS, 16'hFFF0);
        write_reg(REG_ROW_STRIDE, 16'h00FF);
        send_idle_pct = 83;
        recv_idle_pct = 25;
        run_lines(170);
        settle();

        // Zero base and unit stride, full rate, with a long receiver hold-off
        write_reg(REG_BASE_ADDRESS, 16'h0000);
        write_reg(REG_ROW_STRIDE, 16'h0001);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed = 1;
        run_lines(170);
        settle();

        // Zero stride keeps rows on the same address
        write_reg(REG_ROW_STRIDE, 16'h0000);
        write_reg(REG_BASE_ADDRESS, ADDR_BITS'($urandom_range(65535)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_lines(45);
        settle();

        write_reg(REG_BASE_ADDRESS, 16'hFFFF);
        write_reg(REG_ROW_STRIDE, 16'h0080);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_lines(30);
        settle();

        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
